// ----- hdl/tlmf_pkg.sv -----
// Package for the tolerance list match filter.
// Holds sizes, opcodes, register indexes and the controller/datapath structs.
// No dependencies.
package tlmf_pkg;

   localparam int LIST_DEPTH      = 1024;
   localparam int LIST_ADDR_WIDTH = $clog2(LIST_DEPTH);
   localparam int LIST_CNT_WIDTH  = $clog2(LIST_DEPTH + 1);
   localparam int TIME_WIDTH      = 48;
   localparam int MAX_SAMPLES     = 1048576;
   localparam int IDX_WIDTH       = $clog2(MAX_SAMPLES);
   localparam int TOL_WIDTH       = 32;
   localparam int OPCODE_WIDTH    = 2;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [TOL_WIDTH-1:0] TOL_RESET = TOL_WIDTH'(777);

   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_APPEND = 2'd0,
      OP_CLEAR  = 2'd1,
      OP_SAMPLE = 2'd2
   } opcode_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_MATCH_TOLERANCE = 1'd0,
      CSR_EXCLUDE_MODE    = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic append;
      logic clear;
      logic load;
      logic skip;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic skip_needed;
      logic out_free;
   } dp_status_type;

endpackage

// ----- hdl/tlmf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tlmf_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/tlmf_ctrl.sv -----
// Controller of the tolerance list match filter: accepts transactions and
// sequences the skip and finish steps of a sample. Depends on tlmf_pkg.
module tlmf_ctrl
   import tlmf_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic [OPCODE_WIDTH-1:0] req_opcode,
   output logic                    req_stall,
   input  dp_status_type           status,
   output dp_cmd_type              cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_MATCH
   } state_type;

   state_type state_ff, state_in;
   logic      req_stall_ff, req_stall_in;
   logic      accept;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      accept   = req_valid && !req_stall_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (opcode_type'(req_opcode))
                  OP_APPEND: cmd.append = 1'b1;
                  OP_CLEAR:  cmd.clear  = 1'b1;
                  OP_SAMPLE: begin
                     cmd.load = 1'b1;
                     state_in = ST_MATCH;
                  end
                  default: ;
               endcase
            end
         end
         ST_MATCH: begin
            if (status.skip_needed) begin
               cmd.skip = 1'b1;
            end else if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      req_stall_in = (state_in != ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_stall_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_stall_ff <= req_stall_in;
      end
   end

   assign req_stall = req_stall_ff;

endmodule

// ----- hdl/tlmf_dp.sv -----
// Datapath of the tolerance list match filter: list RAM, pointer, series
// counters, window compare and output register. Depends on tlmf_pkg, tlmf_ram.
module tlmf_dp
   import tlmf_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  dp_cmd_type                 cmd,
   output dp_status_type              status,
   input  logic [TIME_WIDTH-1:0]      req_time_value,
   input  logic                       req_last_sample,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wr_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_kept,
   output logic                       rsp_matched,
   output logic [IDX_WIDTH-1:0]       rsp_source_index,
   output logic [IDX_WIDTH-1:0]       rsp_dest_index,
   output logic [TIME_WIDTH-1:0]      rsp_sample_time,
   output logic                       rsp_series_end
);

   logic [TOL_WIDTH-1:0]      tol_ff;
   logic                      exclude_ff;
   logic [LIST_CNT_WIDTH-1:0] count_ff, count_in;
   logic [LIST_CNT_WIDTH-1:0] ptr_ff, ptr_in;
   logic [IDX_WIDTH-1:0]      sample_cnt_ff, sample_cnt_in;
   logic [IDX_WIDTH-1:0]      kept_cnt_ff, kept_cnt_in;
   logic [TIME_WIDTH-1:0]     time_ff;
   logic                      last_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      kept_ff, matched_ff, series_end_ff;
   logic [IDX_WIDTH-1:0]      source_ff, dest_ff;
   logic [TIME_WIDTH-1:0]     sample_time_ff;

   logic [TIME_WIDTH-1:0]     entry;
   logic [TIME_WIDTH-1:0]     tol_ext;
   logic [TIME_WIDTH-1:0]     diff_up, diff_down, diff_abs;
   logic                      entry_valid, above, matched, kept;
   logic                      ram_wr_en;

   tlmf_ram #(
      .WIDTH (TIME_WIDTH),
      .DEPTH (LIST_DEPTH)
   ) u_list_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[LIST_ADDR_WIDTH-1:0]),
      .wr_data (req_time_value),
      .rd_addr (ptr_in[LIST_ADDR_WIDTH-1:0]),
      .rd_data (entry)
   );

   assign ram_wr_en   = cmd.append && (count_ff < LIST_CNT_WIDTH'(LIST_DEPTH));
   assign tol_ext     = {{(TIME_WIDTH-TOL_WIDTH){1'b0}}, tol_ff};
   assign entry_valid = ptr_ff < count_ff;
   assign above       = time_ff > entry;
   assign diff_up     = time_ff - entry;
   assign diff_down   = entry - time_ff;
   assign diff_abs    = above ? diff_up : diff_down;
   assign matched     = entry_valid && (diff_abs < tol_ext);
   assign kept        = exclude_ff ? !matched : matched;

   assign status.skip_needed = entry_valid && above && (diff_up > tol_ext);
   assign status.out_free    = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      sample_cnt_in = sample_cnt_ff;
      kept_cnt_in   = kept_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      if (ram_wr_en) begin
         count_in = count_ff + LIST_CNT_WIDTH'(1);
      end
      if (cmd.clear) begin
         count_in = '0;
         ptr_in   = '0;
      end
      if (cmd.skip) begin
         ptr_in = ptr_ff + LIST_CNT_WIDTH'(1);
      end
      if (cmd.finish) begin
         rsp_valid_in  = 1'b1;
         sample_cnt_in = sample_cnt_ff + IDX_WIDTH'(1);
         if (matched) begin
            ptr_in = ptr_ff + LIST_CNT_WIDTH'(1);
         end
         if (kept) begin
            kept_cnt_in = kept_cnt_ff + IDX_WIDTH'(1);
         end
         if (last_ff) begin
            ptr_in        = '0;
            sample_cnt_in = '0;
            kept_cnt_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff        <= TOL_RESET;
         exclude_ff    <= 1'b0;
         count_ff      <= '0;
         ptr_ff        <= '0;
         sample_cnt_ff <= '0;
         kept_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_MATCH_TOLERANCE: tol_ff     <= csr_wr_data[TOL_WIDTH-1:0];
               CSR_EXCLUDE_MODE:    exclude_ff <= csr_wr_data[0];
               default: ;
            endcase
         end
         count_ff      <= count_in;
         ptr_ff        <= ptr_in;
         sample_cnt_ff <= sample_cnt_in;
         kept_cnt_ff   <= kept_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         time_ff <= req_time_value;
         last_ff <= req_last_sample;
      end
      if (cmd.finish) begin
         kept_ff        <= kept;
         matched_ff     <= matched;
         source_ff      <= sample_cnt_ff;
         dest_ff        <= kept_cnt_ff;
         sample_time_ff <= time_ff;
         series_end_ff  <= last_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kept         = kept_ff;
   assign rsp_matched      = matched_ff;
   assign rsp_source_index = source_ff;
   assign rsp_dest_index   = dest_ff;
   assign rsp_sample_time  = sample_time_ff;
   assign rsp_series_end   = series_end_ff;

`ifndef SYNTH
   a_ptr_within_count: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= count_ff)
      else $error("list pointer beyond list count");

   a_count_within_depth: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LIST_CNT_WIDTH'(LIST_DEPTH))
      else $error("list count beyond depth");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result written over a stalled transaction");

   a_skip_needs_entry: assert property (@(posedge clock) disable iff (reset)
      cmd.skip |=> (ptr_ff == $past(ptr_ff) + LIST_CNT_WIDTH'(1)))
      else $error("skip did not advance the list pointer");
`endif

endmodule

// ----- hdl/tolerance_list_match_filter_top.sv -----
// Top level of the filter; depends on tlmf_pkg, tlmf_ctrl and tlmf_dp.
// An accepted sample is loaded, list entries more than the tolerance below
// it are skipped one by one, and the result is registered once the output
// is free. Append and clear do not stall; requests stall during a sample,
// and a stalled result holds off the next sample's result. Reset
// initialises pointer, counters, valid flag and CSRs, not result data or RAM.
module tolerance_list_match_filter_top
   import tlmf_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [OPCODE_WIDTH-1:0]    req_opcode,
   input  logic [TIME_WIDTH-1:0]      req_time_value,
   input  logic                       req_last_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_kept,
   output logic                       rsp_matched,
   output logic [IDX_WIDTH-1:0]       rsp_source_index,
   output logic [IDX_WIDTH-1:0]       rsp_dest_index,
   output logic [TIME_WIDTH-1:0]      rsp_sample_time,
   output logic                       rsp_series_end,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   tlmf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .status     (status),
      .cmd        (cmd)
   );

   tlmf_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_time_value   (req_time_value),
      .req_last_sample  (req_last_sample),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kept         (rsp_kept),
      .rsp_matched      (rsp_matched),
      .rsp_source_index (rsp_source_index),
      .rsp_dest_index   (rsp_dest_index),
      .rsp_sample_time  (rsp_sample_time),
      .rsp_series_end   (rsp_series_end)
   );

endmodule
